// ===== src/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted polygon measures package
// Widths, limits and saturation bounds shared by the polygon measures block.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

	// Vertex count saturates at this limit.
	localparam int MAX_VERTICES = 1024;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	// Field and accumulator widths.
	localparam int COORD_W  = 16;
	localparam int DIFF_W   = 17;
	localparam int PROD_W   = 34;
	localparam int AREA_W   = 48;
	localparam int PERIM_W  = 27;
	localparam int ROOT_W   = 17;
	localparam int MASS_W   = 26;
	localparam int MOMENT_W = 43;

	// Saturation bounds.
	localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};
	localparam logic [MASS_W-1:0]  MASS_MAX  = {MASS_W{1'b1}};

	// Result status codes.
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_ZERO_MASS = 1'b1;

endpackage

`default_nettype wire

// ===== src/weighted_polygon_measures_top.sv =====
// ----------------------------------------------------------------------------
// Weighted polygon measures
// Accumulates shoelace area, perimeter, total mass and mass moments over the
// vertices of a polygon and reports the measures with the weighted center on
// the marked last vertex. One shared multiplier, one square root step unit
// and one divide step unit run under a sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Fields
//  --------+-----------+---------------------+-------------------------------
//  in      | into      | in_valid / in_stall | point_x point_y point_mass
//          |           |                     | last_point
//  out     | out of    | out_valid/out_stall | signed_area perimeter_len
//          |           |                     | center_x center_y total_mass
//          |           |                     | result_status
//
//  A vertex without an edge (first of a polygon) runs the moment multiplies only.
//  A vertex with an edge runs the moment multiplies and the edge multiplies
//  (dx*dx, dy*dy, dx*sy), then 17 square root steps (2 bits each) of the shared
//  root unit for the edge length. The last vertex adds a closing edge and two 43-step
//  restoring divides for the center (skipped at zero total mass), then loads the result.
//  Reset clears all accumulators; in_stall stays high while an item is in work
//  and while a result waits for an earlier one to be taken.
`default_nettype none

module weighted_polygon_measures_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic signed [15:0]  point_x,
	input  wire logic signed [15:0]  point_y,
	input  wire logic        [15:0]  point_mass,
	input  wire logic                last_point,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [47:0]       signed_area,
	output logic        [26:0]       perimeter_len,
	output logic signed [15:0]       center_x,
	output logic signed [15:0]       center_y,
	output logic        [25:0]       total_mass,
	output logic                     result_status
);

	localparam int CW = wpm_pkg::COORD_W;
	localparam int DW = wpm_pkg::DIFF_W;
	localparam int PW = wpm_pkg::PROD_W;
	localparam int AW = wpm_pkg::AREA_W;
	localparam int LW = wpm_pkg::PERIM_W;
	localparam int RW = wpm_pkg::ROOT_W;
	localparam int MW = wpm_pkg::MASS_W;
	localparam int OW = wpm_pkg::MOMENT_W;
	localparam int NW = wpm_pkg::CNT_W;

	typedef enum logic [3:0] {
		S_IDLE, S_MX, S_MY, S_MACC,
		S_EDX, S_ESQX, S_ESQY, S_EAREA, S_EACC, S_SQRT, S_PADD,
		S_DSET, S_DIV, S_DFIN, S_OUT
	} state_t;

	state_t state_q;

	// Item and polygon state.
	logic signed [CW-1:0] cur_x_q, cur_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CW-1:0]        mass_in_q;
	logic                 last_q;
	logic                 closing_q;
	logic [NW-1:0]        count_q;

	// Accumulators.
	logic signed [AW-1:0] area_q;
	logic [LW-1:0]        perim_q;
	logic [MW-1:0]        mass_q;
	logic signed [OW-1:0] mom_x_q, mom_y_q;

	// Shared multiplier.
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;

	// Edge working registers.
	logic signed [DW-1:0] dx_q, dy_q, sy_q;
	logic [PW-1:0]        sq_q;

	// Square root unit.
	logic [PW-1:0]   rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [4:0]      step_q;
	logic [RW+3:0]   rt_rem;
	logic [RW+3:0]   rt_trial;

	// Divide unit.
	logic [OW-1:0]   quo_q;
	logic [MW-1:0]   drem_q;
	logic [MW:0]     dv_rem;
	logic            div_neg_q;
	logic            div_sel_q;
	logic [5:0]      dstep_q;
	logic signed [CW-1:0] cx_q, cy_q, dv_center;
	logic signed [OW-1:0] dv_mom;
	logic [OW-1:0]   dv_mag;

	// Saturating sums.
	logic signed [AW:0]   area_sum;
	logic signed [AW-1:0] area_next;
	logic [LW:0]          perim_sum;
	logic [MW:0]          mass_sum;
	logic signed [OW:0]   mom_sum;
	logic signed [OW-1:0] mom_next;
	logic signed [OW-1:0] mom_sel;
	logic signed [DW-1:0] ea_x, ea_y, eb_x, eb_y;

	assign in_stall = (state_q != S_IDLE);

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (state_q)
			S_MX: begin
				mul_a = DW'(cur_x_q);
				mul_b = $signed({1'b0, mass_in_q});
			end
			S_MY: begin
				mul_a = DW'(cur_y_q);
				mul_b = $signed({1'b0, mass_in_q});
			end
			S_ESQX: begin
				mul_a = dx_q;
				mul_b = dx_q;
			end
			S_ESQY: begin
				mul_a = dy_q;
				mul_b = dy_q;
			end
			default: begin
				mul_a = dx_q;
				mul_b = sy_q;
			end
		endcase
	end

	// Edge endpoints: previous to current, or current back to first.
	always_comb begin
		if (closing_q) begin
			ea_x = DW'(cur_x_q);
			ea_y = DW'(cur_y_q);
			eb_x = DW'(first_x_q);
			eb_y = DW'(first_y_q);
		end else begin
			ea_x = DW'(prev_x_q);
			ea_y = DW'(prev_y_q);
			eb_x = DW'(cur_x_q);
			eb_y = DW'(cur_y_q);
		end
	end

	// Saturating accumulation of the registered product, plus the perimeter and mass sums.
	always_comb begin
		area_sum = (AW+1)'(area_q) + (AW+1)'(prod_q);
		if (area_sum[AW] != area_sum[AW-1]) begin
			area_next = area_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end else begin
			area_next = area_sum[AW-1:0];
		end
		mom_sel = (state_q == S_MY) ? mom_x_q : mom_y_q;
		mom_sum = (OW+1)'(mom_sel) + (OW+1)'(prod_q);
		if (mom_sum[OW] != mom_sum[OW-1]) begin
			mom_next = mom_sum[OW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
		end else begin
			mom_next = mom_sum[OW-1:0];
		end
		perim_sum = {1'b0, perim_q} + (LW+1)'(root_q);
		mass_sum  = {1'b0, mass_q} + (MW+1)'(mass_in_q);
	end

	// One square root step: two radicand bits per cycle.
	always_comb begin
		rt_rem   = {rem_q, rad_q[PW-1:PW-2]};
		rt_trial = {2'b00, root_q, 2'b01};
	end

	// Divide operand, one restoring divide step and the final center saturation.
	always_comb begin
		dv_mom = div_sel_q ? mom_y_q : mom_x_q;
		dv_mag = dv_mom[OW-1] ? OW'(-dv_mom) : OW'(dv_mom);
		dv_rem = {drem_q, quo_q[OW-1]};
		if (div_neg_q) begin
			dv_center = (quo_q > OW'(32768)) ? 16'sh8000 : -$signed(quo_q[CW-1:0]);
		end else begin
			dv_center = (quo_q > OW'(32767)) ? 16'sh7fff : $signed(quo_q[CW-1:0]);
		end
	end

	// Sequencer with state, datapath and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			first_x_q     <= '0;
			first_y_q     <= '0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			mass_in_q     <= '0;
			last_q        <= 1'b0;
			closing_q     <= 1'b0;
			count_q       <= '0;
			area_q        <= '0;
			perim_q       <= '0;
			mass_q        <= '0;
			mom_x_q       <= '0;
			mom_y_q       <= '0;
			prod_q        <= '0;
			dx_q          <= '0;
			dy_q          <= '0;
			sy_q          <= '0;
			sq_q          <= '0;
			rad_q         <= '0;
			rem_q         <= '0;
			root_q        <= '0;
			step_q        <= '0;
			quo_q         <= '0;
			drem_q        <= '0;
			div_neg_q     <= 1'b0;
			div_sel_q     <= 1'b0;
			dstep_q       <= '0;
			cx_q          <= '0;
			cy_q          <= '0;
			out_valid     <= 1'b0;
			signed_area   <= '0;
			perimeter_len <= '0;
			center_x      <= '0;
			center_y      <= '0;
			total_mass    <= '0;
			result_status <= wpm_pkg::STATUS_OK;
		end else begin
			prod_q <= PW'(mul_a * mul_b);
			// The result load in S_OUT sets the valid flag itself.
			if (out_valid && !out_stall && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cur_x_q   <= point_x;
						cur_y_q   <= point_y;
						mass_in_q <= point_mass;
						last_q    <= last_point;
						closing_q <= 1'b0;
						if (count_q == '0) begin
							first_x_q <= point_x;
							first_y_q <= point_y;
							prev_x_q  <= point_x;
							prev_y_q  <= point_y;
						end
						state_q <= S_MX;
					end
				end
				S_MX: begin
					state_q <= S_MY;
				end
				S_MY: begin
					mom_x_q <= mom_next;
					state_q <= S_MACC;
				end
				S_MACC: begin
					mom_y_q <= mom_next;
					mass_q  <= mass_sum[MW] ? wpm_pkg::MASS_MAX : mass_sum[MW-1:0];
					if (count_q != NW'(wpm_pkg::MAX_VERTICES)) begin
						count_q <= count_q + 1'b1;
					end
					if (count_q != '0) begin
						state_q <= S_EDX;
					end else if (last_q) begin
						closing_q <= 1'b1;
						state_q   <= S_EDX;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EDX: begin
					dx_q <= eb_x - ea_x;
					dy_q <= eb_y - ea_y;
					sy_q <= eb_y + ea_y;
					if (!closing_q) begin
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
					end
					state_q <= S_ESQX;
				end
				S_ESQX: begin
					state_q <= S_ESQY;
				end
				S_ESQY: begin
					sq_q    <= prod_q;
					state_q <= S_EAREA;
				end
				S_EAREA: begin
					sq_q    <= sq_q + prod_q;
					state_q <= S_EACC;
				end
				S_EACC: begin
					area_q  <= area_next;
					rad_q   <= sq_q;
					rem_q   <= '0;
					root_q  <= '0;
					step_q  <= 5'(RW - 1);
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					rad_q <= {rad_q[PW-3:0], 2'b00};
					if (rt_rem >= rt_trial) begin
						rem_q  <= (RW+2)'(rt_rem - rt_trial);
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q  <= rt_rem[RW+1:0];
						root_q <= {root_q[RW-2:0], 1'b0};
					end
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= S_PADD;
					end
				end
				S_PADD: begin
					perim_q <= perim_sum[LW] ? wpm_pkg::PERIM_MAX : perim_sum[LW-1:0];
					if (closing_q) begin
						div_sel_q <= 1'b0;
						state_q   <= S_DSET;
					end else if (last_q) begin
						closing_q <= 1'b1;
						state_q   <= S_EDX;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DSET: begin
					if (mass_q == '0) begin
						cx_q    <= '0;
						cy_q    <= '0;
						state_q <= S_OUT;
					end else begin
						// Divide the moment magnitude and restore the sign at the end.
						div_neg_q <= dv_mom[OW-1];
						quo_q     <= dv_mag;
						drem_q    <= '0;
						dstep_q   <= 6'(OW - 1);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					if (dv_rem >= {1'b0, mass_q}) begin
						drem_q <= MW'(dv_rem - {1'b0, mass_q});
						quo_q  <= {quo_q[OW-2:0], 1'b1};
					end else begin
						drem_q <= dv_rem[MW-1:0];
						quo_q  <= {quo_q[OW-2:0], 1'b0};
					end
					dstep_q <= dstep_q - 1'b1;
					if (dstep_q == '0) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: begin
					if (div_sel_q) begin
						cy_q    <= dv_center;
						state_q <= S_OUT;
					end else begin
						cx_q      <= dv_center;
						div_sel_q <= 1'b1;
						state_q   <= S_DSET;
					end
				end
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid     <= 1'b1;
						signed_area   <= area_q >>> 1;
						perimeter_len <= perim_q;
						center_x      <= cx_q;
						center_y      <= cy_q;
						total_mass    <= mass_q;
						result_status <= (mass_q == '0) ? wpm_pkg::STATUS_ZERO_MASS
						                                : wpm_pkg::STATUS_OK;
						area_q        <= '0;
						perim_q       <= '0;
						mass_q        <= '0;
						mom_x_q       <= '0;
						mom_y_q       <= '0;
						count_q       <= '0;
						first_x_q     <= '0;
						first_y_q     <= '0;
						prev_x_q      <= '0;
						prev_y_q      <= '0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// An accepted item always keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block ready right after accepting an item");

	// A zero-mass result carries a zero center.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_status |-> center_x == '0 && center_y == '0)
		else $error("zero-mass result with nonzero center");

	// The error status is set exactly when the total mass is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_status == (total_mass == '0)))
		else $error("status does not match total mass");

endmodule

`default_nettype wire
